[rtl/sak_pkg.sv]
// ----------------------------------------------------------------------------
// sak_pkg
// Shared constants, state encoding and control structs of the held key set.
// ----------------------------------------------------------------------------
`default_nettype none

package sak_pkg;

    // set size and key range
    localparam int SLOTS    = 12;
    localparam int NUM_KEYS = 59;

    // field widths
    localparam int KEY_W = 6;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // request codes
    localparam logic REQ_ON  = 1'b0;
    localparam logic REQ_OFF = 1'b1;

    // controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic apply;   // update the set with the accepted request
        logic load;    // load the next result into the output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;    // the next result to load is the final one
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/sak_if.sv]
// ----------------------------------------------------------------------------
// sak_if
// Request and result channels of the held key set, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface key_req_if;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [sak_pkg::KEY_W-1:0] key_index;

    modport source (output valid, output req_type, output key_index, input ready);
    modport sink   (input valid, input req_type, input key_index, output ready);
endinterface

interface key_res_if;
    logic                    valid;
    logic                    ready;
    logic [sak_pkg::KEY_W-1:0] held_key;
    logic                    is_last;
    logic                    set_empty;
    logic                    dropped;

    modport source (output valid, output held_key, output is_last, output set_empty,
                    output dropped, input ready);
    modport sink   (input valid, input held_key, input is_last, input set_empty,
                    input dropped, output ready);
endinterface

`default_nettype wire

[rtl/sak_datapath.sv]
// ----------------------------------------------------------------------------
// sak_datapath
// Sorted slot list with per-slot insert/delete shifting, and the result
// register that walks the list in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module sak_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sak_pkg::dp_cmd_t            cmd,
    output sak_pkg::dp_status_t              status,
    input  wire logic                        req_type,
    input  wire logic [sak_pkg::KEY_W-1:0]   key_index,
    output logic [sak_pkg::KEY_W-1:0]        held_key,
    output logic                             is_last,
    output logic                             set_empty,
    output logic                             dropped
);

    localparam int SLOTS = sak_pkg::SLOTS;
    localparam int KEY_W = sak_pkg::KEY_W;
    localparam int IDX_W = sak_pkg::IDX_W;
    localparam int CNT_W = sak_pkg::CNT_W;

    // slot keys, kept in ascending order; entries at or above the count are stale
    logic [KEY_W-1:0] key_reg  [SLOTS];
    logic [KEY_W-1:0] ins_next [SLOTS];
    logic [KEY_W-1:0] del_next [SLOTS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             drop_reg;
    logic             drop_next;

    // result register
    logic [KEY_W-1:0] held_reg;
    logic             last_reg;
    logic             empty_reg;
    logic             dropped_reg;

    logic [SLOTS-1:0] lt;
    logic [SLOTS-1:0] eq;
    logic             in_range;
    logic             found;
    logic             full;
    logic             do_ins;
    logic             do_del;

    // per-slot compares against the request key
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            lt[i] = (CNT_W'(i) < cnt_reg) && (key_reg[i] < key_index);
            eq[i] = (CNT_W'(i) < cnt_reg) && (key_reg[i] == key_index);
        end
    end

    assign in_range = ({1'b0, key_index} < (KEY_W+1)'(sak_pkg::NUM_KEYS));
    assign found    = |eq;
    assign full     = (cnt_reg == CNT_W'(SLOTS));
    assign do_ins   = in_range && (req_type == sak_pkg::REQ_ON) && !found && !full;
    assign do_del   = in_range && (req_type == sak_pkg::REQ_OFF) && found;
    assign drop_next = in_range && (req_type == sak_pkg::REQ_ON) && !found && full;

    // shifted slot contents for insert and delete
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_slot
            if (g == 0)
            begin : g_first
                assign ins_next[g] = lt[g] ? key_reg[g] : key_index;
            end
            else
            begin : g_rest
                assign ins_next[g] = lt[g]     ? key_reg[g]   :
                                     lt[g-1]   ? key_index    : key_reg[g-1];
            end
            if (g == SLOTS - 1)
            begin : g_top
                assign del_next[g] = key_reg[g];
            end
            else
            begin : g_below
                assign del_next[g] = lt[g] ? key_reg[g] : key_reg[g+1];
            end
        end
    endgenerate

    // slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cmd.apply && do_ins)
            begin
                key_reg[i] <= ins_next[i];
            end
            else if (cmd.apply && do_del)
            begin
                key_reg[i] <= del_next[i];
            end
        end
    end

    // count and walk index
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.apply)
        begin
            idx_next = '0;
            if (do_ins)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else if (do_del)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        else if (cmd.load)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // drop flag of the current request
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            drop_reg <= drop_next;
        end
    end

    assign status.last = (cnt_reg == '0) || ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

    // result register load
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            held_reg    <= (cnt_reg == '0) ? '0 : key_reg[idx_reg];
            last_reg    <= status.last;
            empty_reg   <= (cnt_reg == '0);
            dropped_reg <= drop_reg;
        end
    end

    assign held_key  = held_reg;
    assign is_last   = last_reg;
    assign set_empty = empty_reg;
    assign dropped   = dropped_reg;

endmodule

`default_nettype wire

[rtl/sak_ctrl.sv]
// ----------------------------------------------------------------------------
// sak_ctrl
// Controller: takes one request, then steps the result walk under the
// output handshake and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sak_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output sak_pkg::dp_cmd_t           cmd,
    input  wire sak_pkg::dp_status_t   status
);

    sak_pkg::state_t state_reg;
    sak_pkg::state_t state_next;
    logic            valid_reg;
    logic            valid_next;
    logic            out_free;

    assign out_free  = !valid_reg || res_ready;
    assign req_ready = (state_reg == sak_pkg::ST_IDLE);
    assign res_valid = valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd.apply  = 1'b0;
        cmd.load   = 1'b0;
        unique case (state_reg)
            sak_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.apply  = 1'b1;
                    state_next = sak_pkg::ST_EMIT;
                end
            end
            sak_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load = 1'b1;
                    if (status.last)
                    begin
                        state_next = sak_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sak_pkg::ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sak_pkg::ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sorted_active_key_set.sv]
// ----------------------------------------------------------------------------
// sorted_active_key_set
// Set of held keyboard keys; after each on/off request the held keys are
// sent out in ascending order, one word per result, the last one marked.
// ----------------------------------------------------------------------------
//  channel  dir  word contents
//  req      in   req_type, key_index
//  res      out  held_key, is_last, set_empty, dropped
//
//  a request is taken in the idle state, then its max(n,1) results follow
//  one per cycle while the sink is ready (n = keys held), stepped by the
//  result register walk over the sorted slot list
//  the last result may still wait in the output register while the next
//  request is taken; a stalled sink pauses the walk
//  reset empties the set at once
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_active_key_set (
    input  wire logic  clk,
    input  wire logic  rst_n,
    key_req_if.sink    req,
    key_res_if.source  res
);

    sak_pkg::dp_cmd_t    cmd;
    sak_pkg::dp_status_t status;

    // control
    sak_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // slot list and result register
    sak_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_type  (req.req_type),
        .key_index (req.key_index),
        .held_key  (res.held_key),
        .is_last   (res.is_last),
        .set_empty (res.set_empty),
        .dropped   (res.dropped)
    );

endmodule

`default_nettype wire

[rtl/sak_check.sv]
// ----------------------------------------------------------------------------
// sak_check
// Port-level checks of the held key set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sak_check (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_ready,
    input wire logic                       res_valid,
    input wire logic                       res_ready,
    input wire logic [sak_pkg::KEY_W-1:0]  held_key,
    input wire logic                       is_last,
    input wire logic                       set_empty,
    input wire logic                       dropped
);

    // stalled result word holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(held_key) && $stable(is_last)
            && $stable(set_empty) && $stable(dropped))
        else $error("result word changed while stalled");

    // empty set gives a single zero word
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && set_empty |-> is_last && (held_key == '0))
        else $error("empty result not a single zero word");

    // a dropped request is never flagged on an empty set
    a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && dropped |-> !set_empty)
        else $error("dropped flagged on empty set");

    // no request taken in the middle of a result list
    a_busy_mid_list: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_last |-> !req_ready)
        else $error("request ready before the last result");

    // a taken request blocks the next one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("back to back requests taken");

endmodule

bind sorted_active_key_set sak_check u_sak_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .held_key  (res.held_key),
    .is_last   (res.is_last),
    .set_empty (res.set_empty),
    .dropped   (res.dropped)
);

`default_nettype wire
